// ===== rtl/core/q8mm_pkg.sv =====
// q8mm_pkg: shared types, widths, codes and helpers for the q8 matmul tile core
// used by q8mm_scale_acc and q8_block_quantized_matmul_tile_core; no dependencies
`default_nettype none

package q8mm_pkg;

    // default tile geometry
    localparam int DEF_TILE_ROWS  = 16;
    localparam int DEF_TILE_COLS  = 64;
    localparam int DEF_TILE_DEPTH = 64;
    localparam int DEF_BLOCK_SIZE = 32;

    // payload field widths
    localparam int ACTION_W = 2;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 6;
    localparam int K_W      = 6;
    localparam int A_W      = 16;
    localparam int Q_W      = 8;
    localparam int SCALE_W  = 16;
    localparam int ACC_W    = 48;
    localparam int STATUS_W = 2;

    // configuration port and register widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_LEN_W  = 7;
    localparam int CFG_ROWS_W = 5;
    localparam int CFG_COLS_W = 7;

    // inner position counters, wide enough for length plus one block
    localparam int POS_W = CFG_LEN_W + 1;

    // a times quant product width
    localparam int PRD_W = A_W + Q_W;

    // fp16 scale decode
    localparam int MAN_W   = 11;
    localparam int EXP_W   = 5;
    localparam logic [EXP_W-1:0] EXP_ALL_ONES  = 5'h1F;
    localparam logic [EXP_W-1:0] EXP_UNIT_SHIFT = 5'd17;

    // configuration reset values
    localparam logic [CFG_LEN_W-1:0]  RST_INNER_LENGTH = 7'd64;
    localparam logic [CFG_ROWS_W-1:0] RST_ROW_COUNT    = 5'd16;
    localparam logic [CFG_COLS_W-1:0] RST_COL_COUNT    = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT    = 2'd2;

    // item actions
    localparam logic [ACTION_W-1:0] ACT_WRITE_A     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_QUANT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE_SCALE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NON_FINITE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SATURATED   = 2'd3;

    // 48-bit accumulator limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // control from the sequencer to the block scaler
    typedef struct packed {
        logic clear;
        logic start;
    } sacc_ctrl_t;

    // status from the block scaler back to the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } sacc_stat_t;

    // fp16 field helpers
    function automatic logic [EXP_W-1:0] fp16_exp(input logic [SCALE_W-1:0] h);
        return h[14:10];
    endfunction

    function automatic logic [MAN_W-1:0] fp16_man(input logic [SCALE_W-1:0] h);
        return {1'b1, h[9:0]};
    endfunction

    function automatic logic fp16_sign(input logic [SCALE_W-1:0] h);
        return h[15];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/q8mm_scale_acc.sv =====
// q8mm_scale_acc: scales one block sum by its fp16 scale and adds it into the
// saturating 48-bit accumulator over four registered steps; uses q8mm_pkg
`default_nettype none

module q8mm_scale_acc
    import q8mm_pkg::*;
#(
    parameter  int BLOCK_SIZE = DEF_BLOCK_SIZE,
    localparam int BSUM_W     = PRD_W + $clog2(BLOCK_SIZE)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire sacc_ctrl_t               ctrl,
    input  wire logic signed [BSUM_W-1:0] bsum,
    input  wire logic [SCALE_W-1:0]       scale,
    output sacc_stat_t                    stat,
    output logic signed [ACC_W-1:0]       acc
);

    localparam int MUL_W  = BSUM_W + MAN_W;
    localparam int MULX_W = MUL_W + 1;
    localparam int MAG_W  = MUL_W - 1;
    localparam int SH_W   = MAG_W + 14;
    localparam int WIDE_W = SH_W + 2;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = {{(WIDE_W-ACC_W){1'b0}}, ACC_MAX};
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = {{(WIDE_W-ACC_W){1'b1}}, ACC_MIN};

    logic                     v1_reg, v2_reg, v3_reg, done_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic [EXP_W-1:0]         ex_reg;
    logic                     sgn_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [SH_W-1:0]          sh_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     sat_reg;

    logic signed [MULX_W-1:0] mul_full;
    logic [MAG_W-1:0]         mag_next;
    logic [SH_W-1:0]          sh_next;
    logic [EXP_W-1:0]         rsh;
    logic [MAG_W:0]           rnd;
    logic signed [WIDE_W-1:0] acc_ext;
    logic signed [WIDE_W-1:0] term_ext;
    logic signed [WIDE_W-1:0] sum_wide;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     clamp;

    // step one: block sum times mantissa
    assign mul_full = MULX_W'(bsum) * MULX_W'($signed({1'b0, fp16_man(scale)}));

    // step two: magnitude, subnormal and zero scales flush to nothing
    always_comb begin
        if (ex_reg == '0) begin
            mag_next = '0;
        end else if (mul_reg[MUL_W-1]) begin
            mag_next = MAG_W'(-mul_reg);
        end else begin
            mag_next = MAG_W'(mul_reg);
        end
    end

    // step three: exponent shift, right shifts round half away from zero
    always_comb begin
        rsh = EXP_UNIT_SHIFT - ex_reg;
        rnd = (MAG_W+1)'(mag_reg) + ((MAG_W+1)'(1) << (rsh - 5'd1));
        if (ex_reg >= EXP_UNIT_SHIFT) begin
            sh_next = SH_W'(mag_reg) << (ex_reg - EXP_UNIT_SHIFT);
        end else begin
            sh_next = SH_W'(rnd >> rsh);
        end
    end

    // step four: signed add into the accumulator and clamp
    always_comb begin
        acc_ext  = {{(WIDE_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        term_ext = {2'b00, sh_reg};
        sum_wide = neg_reg ? (acc_ext - term_ext) : (acc_ext + term_ext);
        clamp    = 1'b1;
        if (sum_wide > WIDE_MAX) begin
            acc_next = ACC_MAX;
        end else if (sum_wide < WIDE_MIN) begin
            acc_next = ACC_MIN;
        end else begin
            acc_next = ACC_W'(sum_wide);
            clamp    = 1'b0;
        end
    end

    // step valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= ctrl.start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // accumulator and saturation flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (ctrl.clear) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (v3_reg) begin
            acc_reg <= acc_next;
            sat_reg <= sat_reg | clamp;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            mul_reg <= MUL_W'(mul_full);
            ex_reg  <= fp16_exp(scale);
            sgn_reg <= fp16_sign(scale);
        end
        if (v1_reg) begin
            mag_reg <= mag_next;
            neg_reg <= mul_reg[MUL_W-1] ^ sgn_reg;
        end
        if (v2_reg) begin
            sh_reg <= sh_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/q8_block_quantized_matmul_tile_core.sv =====
// q8_block_quantized_matmul_tile_core: top level of the q8 matmul tile, with the
// a, quant and scale memories and the item sequencer; uses q8mm_pkg, q8mm_scale_acc
`default_nettype none

// Usage
//  s_ channel: one transaction per item. Actions write an A element, a B quant
//  or a B block scale into on-chip memory, or compute one C element.
//  m_ channel: exactly one result transaction per item, in item order; writes
//  return c_value zero with status ok or bad index.
//  cfg_ channel: writes inner_length, row_count, col_count; always ready. It is
//  only to be written while no item is in flight; the block does not enforce it.
//  Sequence: a write item is done the cycle it is accepted; its result then
//  passes through the holding register and the output register. A compute item
//  first checks all scales in use, then per block does one multiply-accumulate
//  per cycle from the a and quant memory read ports, through the read, product
//  and sum registers, and then the four scaling steps of the block scaler.
//  Its time grows with the inner length walked through the two memories.
//  Items: one item is worked on at a time; with the receiver ready the
//  next item is taken the cycle the result shows.
//  Stall: a finished result waits in a holding register and then the output
//  register; the next item is taken once the holding register is free.
//  Reset: aresetn is synchronous, active low; it clears control and loads the
//  default register values. Memory contents are undefined until written.
module q8_block_quantized_matmul_tile_core
    import q8mm_pkg::*;
#(
    parameter int TILE_ROWS  = DEF_TILE_ROWS,
    parameter int TILE_COLS  = DEF_TILE_COLS,
    parameter int TILE_DEPTH = DEF_TILE_DEPTH,
    parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // item channel
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [ACTION_W-1:0]        s_action,
    input  wire logic [ROW_W-1:0]           s_row_index,
    input  wire logic [COL_W-1:0]           s_col_index,
    input  wire logic [K_W-1:0]             s_k_index,
    input  wire logic signed [A_W-1:0]      s_a_value,
    input  wire logic signed [Q_W-1:0]      s_b_quant,
    input  wire logic [SCALE_W-1:0]         s_b_scale,
    // result channel
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [ACC_W-1:0]         m_c_value,
    output logic [STATUS_W-1:0]             m_status,
    // configuration channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int BPR     = (TILE_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int A_DEPTH = TILE_ROWS * TILE_DEPTH;
    localparam int Q_DEPTH = TILE_COLS * TILE_DEPTH;
    localparam int S_DEPTH = TILE_COLS * BPR;
    localparam int A_AW    = $clog2(A_DEPTH);
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int S_AW    = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
    localparam int BSUM_W  = PRD_W + $clog2(BLOCK_SIZE);
    localparam int KB_W    = K_W + CFG_LEN_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_HDR   = 5'b00100,
        ST_MAC   = 5'b01000,
        ST_SCALE = 5'b10000
    } state_t;

    // memories
    logic [A_W-1:0]     a_mem [A_DEPTH];
    logic [Q_W-1:0]     q_mem [Q_DEPTH];
    logic [SCALE_W-1:0] s_mem [S_DEPTH];

    // configuration
    logic [CFG_LEN_W-1:0]  inner_length_reg;
    logic [CFG_ROWS_W-1:0] row_count_reg;
    logic [CFG_COLS_W-1:0] col_count_reg;

    // sequencer state
    state_t                  state_reg, state_next;
    logic [CFG_LEN_W-1:0]    len_reg, len_next;
    logic [A_AW-1:0]         a_base_reg, a_base_next;
    logic [Q_AW-1:0]         q_base_reg, q_base_next;
    logic [S_AW-1:0]         s_base_reg, s_base_next;
    logic [POS_W-1:0]        blk_reg, blk_next;
    logic [POS_W-1:0]        blk_start_reg, blk_start_next;
    logic [POS_W-1:0]        blk_end_reg, blk_end_next;
    logic [POS_W-1:0]        k_reg, k_next;
    logic                    scan_v_reg, scan_v_next;
    logic                    bad_reg, bad_next;
    logic                    rd_v_reg, rd_v_next;
    logic                    prod_v_reg, prod_v_next;
    logic signed [PRD_W-1:0] prod_reg, prod_next;
    logic signed [BSUM_W-1:0] bsum_reg, bsum_next;

    // result holding and output registers
    logic                    pend_v_reg, pend_v_next;
    logic signed [ACC_W-1:0] pend_c_reg, pend_c_next;
    logic [STATUS_W-1:0]     pend_status_reg, pend_status_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [ACC_W-1:0] m_c_value_reg, m_c_value_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;

    // memory ports
    logic                    a_we, q_we, s_we;
    logic [A_AW-1:0]         a_waddr, a_raddr;
    logic [Q_AW-1:0]         q_waddr, q_raddr;
    logic [S_AW-1:0]         s_waddr, s_raddr;
    logic signed [A_W-1:0]   a_rd_reg;
    logic signed [Q_W-1:0]   q_rd_reg;
    logic [SCALE_W-1:0]      s_rd_reg;

    // effective geometry and index checks
    logic [CFG_LEN_W-1:0]    len_eff;
    logic [CFG_ROWS_W-1:0]   rows_eff;
    logic [CFG_COLS_W-1:0]   cols_eff;
    logic                    row_ok, col_ok, k_ok, blk_ok;
    logic [A_AW-1:0]         a_row_base;
    logic [Q_AW-1:0]         q_col_base;
    logic [S_AW-1:0]         s_col_base;
    logic [POS_W-1:0]        start_plus_blk;
    logic                    scan_issue, mac_issue;
    logic                    s_accept, move;

    sacc_ctrl_t              sacc_ctrl;
    sacc_stat_t              sacc_stat;
    logic signed [ACC_W-1:0] sacc_acc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !pend_v_reg;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_c_value = m_c_value_reg;
    assign m_status  = m_status_reg;

    // clip configuration to the tile size
    assign len_eff  = (int'(inner_length_reg) > TILE_DEPTH) ? CFG_LEN_W'(TILE_DEPTH)
                                                          : inner_length_reg;
    assign rows_eff = (int'(row_count_reg) > TILE_ROWS) ? CFG_ROWS_W'(TILE_ROWS)
                                                       : row_count_reg;
    assign cols_eff = (int'(col_count_reg) > TILE_COLS) ? CFG_COLS_W'(TILE_COLS)
                                                       : col_count_reg;

    assign row_ok = CFG_ROWS_W'(s_row_index) < rows_eff;
    assign col_ok = CFG_COLS_W'(s_col_index) < cols_eff;
    assign k_ok   = CFG_LEN_W'(s_k_index) < len_eff;
    assign blk_ok = (KB_W'(s_k_index) * KB_W'(BLOCK_SIZE)) < KB_W'(len_eff);

    // row and column base addresses of the incoming item
    assign a_row_base = A_AW'(A_AW'(s_row_index) * A_AW'(TILE_DEPTH));
    assign q_col_base = Q_AW'(Q_AW'(s_col_index) * Q_AW'(TILE_DEPTH));
    assign s_col_base = S_AW'(S_AW'(s_col_index) * S_AW'(BPR));

    assign a_waddr = a_row_base + A_AW'(s_k_index);
    assign q_waddr = q_col_base + Q_AW'(s_k_index);
    assign s_waddr = s_col_base + S_AW'(s_k_index);

    // read addresses follow the walk counters
    assign a_raddr = a_base_reg + A_AW'(k_reg);
    assign q_raddr = q_base_reg + Q_AW'(k_reg);
    assign s_raddr = s_base_reg + S_AW'(blk_reg);

    assign start_plus_blk = blk_start_reg + POS_W'(BLOCK_SIZE);
    assign scan_issue     = blk_start_reg < POS_W'(len_reg);
    assign mac_issue      = k_reg < blk_end_reg;

    assign move = pend_v_reg && (!m_valid_reg || m_ready);

    // sequencer and result path
    always_comb begin
        state_next       = state_reg;
        len_next         = len_reg;
        a_base_next      = a_base_reg;
        q_base_next      = q_base_reg;
        s_base_next      = s_base_reg;
        blk_next         = blk_reg;
        blk_start_next   = blk_start_reg;
        blk_end_next     = blk_end_reg;
        k_next           = k_reg;
        scan_v_next      = 1'b0;
        bad_next         = bad_reg;
        rd_v_next        = 1'b0;
        prod_v_next      = 1'b0;
        prod_next        = prod_reg;
        bsum_next        = bsum_reg;
        pend_v_next      = pend_v_reg && !move;
        pend_c_next      = pend_c_reg;
        pend_status_next = pend_status_reg;
        m_valid_next     = m_valid_reg;
        m_c_value_next   = m_c_value_reg;
        m_status_next    = m_status_reg;
        a_we             = 1'b0;
        q_we             = 1'b0;
        s_we             = 1'b0;
        sacc_ctrl        = '0;

        // output register
        if (move) begin
            m_valid_next   = 1'b1;
            m_c_value_next = pend_c_reg;
            m_status_next  = pend_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pend_c_next = '0;
                    unique case (s_action)
                        ACT_WRITE_A: begin
                            a_we             = row_ok && k_ok;
                            pend_v_next      = 1'b1;
                            pend_status_next = (row_ok && k_ok) ? STAT_OK : STAT_BAD_INDEX;
                        end
                        ACT_WRITE_QUANT: begin
                            q_we             = col_ok && k_ok;
                            pend_v_next      = 1'b1;
                            pend_status_next = (col_ok && k_ok) ? STAT_OK : STAT_BAD_INDEX;
                        end
                        ACT_WRITE_SCALE: begin
                            s_we             = col_ok && blk_ok;
                            pend_v_next      = 1'b1;
                            pend_status_next = (col_ok && blk_ok) ? STAT_OK : STAT_BAD_INDEX;
                        end
                        ACT_COMPUTE: begin
                            if (!(row_ok && col_ok)) begin
                                pend_v_next      = 1'b1;
                                pend_status_next = STAT_BAD_INDEX;
                            end else begin
                                len_next       = len_eff;
                                a_base_next    = a_row_base;
                                q_base_next    = q_col_base;
                                s_base_next    = s_col_base;
                                blk_next       = '0;
                                blk_start_next = '0;
                                bad_next       = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            // check every scale in use for an all-ones exponent
            ST_SCAN: begin
                if (scan_issue) begin
                    blk_next       = blk_reg + POS_W'(1);
                    blk_start_next = start_plus_blk;
                    scan_v_next    = 1'b1;
                end
                if (scan_v_reg && (fp16_exp(s_rd_reg) == EXP_ALL_ONES)) begin
                    bad_next = 1'b1;
                end
                if (!scan_issue && !scan_v_reg) begin
                    if (bad_reg) begin
                        pend_v_next      = 1'b1;
                        pend_c_next      = '0;
                        pend_status_next = STAT_NON_FINITE;
                        state_next       = ST_IDLE;
                    end else begin
                        blk_next        = '0;
                        blk_start_next  = '0;
                        sacc_ctrl.clear = 1'b1;
                        state_next      = ST_HDR;
                    end
                end
            end

            // open the next block, its scale read issues here
            ST_HDR: begin
                if (scan_issue) begin
                    k_next       = blk_start_reg;
                    blk_end_next = (start_plus_blk < POS_W'(len_reg)) ? start_plus_blk
                                                                      : POS_W'(len_reg);
                    bsum_next    = '0;
                    state_next   = ST_MAC;
                end else begin
                    pend_v_next      = 1'b1;
                    pend_c_next      = sacc_acc;
                    pend_status_next = sacc_stat.sat ? STAT_SATURATED : STAT_OK;
                    state_next       = ST_IDLE;
                end
            end

            // read, multiply, accumulate over the block
            ST_MAC: begin
                if (mac_issue) begin
                    k_next    = k_reg + POS_W'(1);
                    rd_v_next = 1'b1;
                end
                if (rd_v_reg) begin
                    prod_next   = PRD_W'(a_rd_reg) * PRD_W'(q_rd_reg);
                    prod_v_next = 1'b1;
                end
                if (prod_v_reg) begin
                    bsum_next = bsum_reg + BSUM_W'(prod_reg);
                end
                if (!mac_issue && !rd_v_reg && !prod_v_reg) begin
                    sacc_ctrl.start = 1'b1;
                    state_next      = ST_SCALE;
                end
            end

            // wait for the scaled block to land in the accumulator
            ST_SCALE: begin
                if (sacc_stat.done) begin
                    blk_next       = blk_reg + POS_W'(1);
                    blk_start_next = start_plus_blk;
                    state_next     = ST_HDR;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            scan_v_reg       <= 1'b0;
            rd_v_reg         <= 1'b0;
            prod_v_reg       <= 1'b0;
            pend_v_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            inner_length_reg <= RST_INNER_LENGTH;
            row_count_reg    <= RST_ROW_COUNT;
            col_count_reg    <= RST_COL_COUNT;
        end else begin
            state_reg  <= state_next;
            scan_v_reg <= scan_v_next;
            rd_v_reg   <= rd_v_next;
            prod_v_reg <= prod_v_next;
            pend_v_reg <= pend_v_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_INNER_LENGTH: inner_length_reg <= CFG_LEN_W'(cfg_data);
                    CFG_ROW_COUNT:    row_count_reg    <= CFG_ROWS_W'(cfg_data);
                    CFG_COL_COUNT:    col_count_reg    <= CFG_COLS_W'(cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        len_reg         <= len_next;
        a_base_reg      <= a_base_next;
        q_base_reg      <= q_base_next;
        s_base_reg      <= s_base_next;
        blk_reg         <= blk_next;
        blk_start_reg   <= blk_start_next;
        blk_end_reg     <= blk_end_next;
        k_reg           <= k_next;
        bad_reg         <= bad_next;
        prod_reg        <= prod_next;
        bsum_reg        <= bsum_next;
        pend_c_reg      <= pend_c_next;
        pend_status_reg <= pend_status_next;
        m_c_value_reg   <= m_c_value_next;
        m_status_reg    <= m_status_next;
    end

    // a memory
    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= s_a_value;
        end
        a_rd_reg <= a_mem[a_raddr];
    end

    // quant memory
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= s_b_quant;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

    // scale memory
    always_ff @(posedge aclk) begin
        if (s_we) begin
            s_mem[s_waddr] <= s_b_scale;
        end
        s_rd_reg <= s_mem[s_raddr];
    end

    // block scaling and accumulation
    q8mm_scale_acc #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_scale_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sacc_ctrl),
        .bsum    (bsum_reg),
        .scale   (s_rd_reg),
        .stat    (sacc_stat),
        .acc     (sacc_acc)
    );

endmodule

`default_nettype wire

// ===== test/q8_block_quantized_matmul_tile_core_tb.sv =====
// q8_block_quantized_matmul_tile_core_tb: self-checking bench for the q8 matmul tile core,
// with a scoreboard that models the a/quant/scale stores and predicts each result
// depends on q8mm_pkg and q8_block_quantized_matmul_tile_core
module q8_block_quantized_matmul_tile_core_tb;
    import q8mm_pkg::*;

    localparam int TILE_R = DEF_TILE_ROWS;
    localparam int TILE_C = DEF_TILE_COLS;
    localparam int TILE_D = DEF_TILE_DEPTH;
    localparam int BLK = DEF_BLOCK_SIZE;
    localparam int BLOCKS_PER_ROW = (TILE_D + BLK - 1) / BLK;
    localparam int ITEM_GOAL = 1950;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic [ACTION_W-1:0] WRITE_ACTIONS [3] =
        '{ACT_WRITE_A, ACT_WRITE_QUANT, ACT_WRITE_SCALE};

    typedef struct {
        logic [ACTION_W-1:0]     action;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [K_W-1:0]          k;
        logic signed [A_W-1:0]   a;
        logic signed [Q_W-1:0]   q;
        logic [SCALE_W-1:0]      scale;
    } tile_item_t;

    typedef struct {
        logic [ACC_W-1:0]    c;
        logic [STATUS_W-1:0] status;
    } c_result_t;

    // store model, register copy and queue of predicted c elements
    class c_element_scoreboard;
        logic [A_W-1:0]     a_mem [TILE_R * TILE_D];
        logic [Q_W-1:0]     q_mem [TILE_C * TILE_D];
        logic [SCALE_W-1:0] scale_mem [TILE_C * BLOCKS_PER_ROW];
        bit                 a_set [TILE_R * TILE_D];
        bit                 q_set [TILE_C * TILE_D];
        bit                 scale_set [TILE_C * BLOCKS_PER_ROW];
        logic [CFG_LEN_W-1:0]  inner_len;
        logic [CFG_ROWS_W-1:0] row_cfg;
        logic [CFG_COLS_W-1:0] col_cfg;
        c_result_t pending_c [$];
        int errors;
        int results_seen;

        function new();
            inner_len = RST_INNER_LENGTH;
            row_cfg = RST_ROW_COUNT;
            col_cfg = RST_COL_COUNT;
            errors = 0;
            results_seen = 0;
        endfunction

        function int eff_len();
            return (int'(inner_len) > TILE_D) ? TILE_D : int'(inner_len);
        endfunction

        function int eff_rows();
            return (int'(row_cfg) > TILE_R) ? TILE_R : int'(row_cfg);
        endfunction

        function int eff_cols();
            return (int'(col_cfg) > TILE_C) ? TILE_C : int'(col_cfg);
        endfunction

        function int eff_blocks();
            return (eff_len() + BLK - 1) / BLK;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INNER_LENGTH: inner_len = data;
                CFG_ROW_COUNT:    row_cfg = data[CFG_ROWS_W-1:0];
                CFG_COL_COUNT:    col_cfg = data;
                default: ;
            endcase
        endfunction

        // a compute is safe when it errors out early or every entry it reads was written
        function bit can_compute(int r, int c);
            int k;
            int b;
            if (r >= eff_rows() || c >= eff_cols()) return 1'b1;
            for (k = 0; k < eff_len(); k++)
                if (!a_set[r * TILE_D + k] || !q_set[c * TILE_D + k]) return 1'b0;
            for (b = 0; b < eff_blocks(); b++)
                if (!scale_set[c * BLOCKS_PER_ROW + b]) return 1'b0;
            return 1'b1;
        endfunction

        // update the stores and push the expected result for one accepted item
        function void predict_item(tile_item_t it);
            int len;
            int nblk;
            int ri;
            int ci;
            int ki;
            int b;
            int k;
            int hi;
            int ex;
            logic [SCALE_W-1:0] h;
            logic [STATUS_W-1:0] st;
            longint acc;
            longint bsum;
            longint prod;
            longint term;
            longint unsigned mag;
            bit neg;
            bit non_finite;
            bit sat;
            c_result_t r;
            len = eff_len();
            nblk = eff_blocks();
            ri = int'(it.row);
            ci = int'(it.col);
            ki = int'(it.k);
            st = STAT_OK;
            acc = 0;
            non_finite = 1'b0;
            sat = 1'b0;
            case (it.action)
                ACT_WRITE_A:
                    if (ri < eff_rows() && ki < len) begin
                        a_mem[ri * TILE_D + ki] = it.a;
                        a_set[ri * TILE_D + ki] = 1'b1;
                    end else begin
                        st = STAT_BAD_INDEX;
                    end
                ACT_WRITE_QUANT:
                    if (ci < eff_cols() && ki < len) begin
                        q_mem[ci * TILE_D + ki] = it.q;
                        q_set[ci * TILE_D + ki] = 1'b1;
                    end else begin
                        st = STAT_BAD_INDEX;
                    end
                ACT_WRITE_SCALE:
                    if (ci < eff_cols() && ki < nblk) begin
                        scale_mem[ci * BLOCKS_PER_ROW + ki] = it.scale;
                        scale_set[ci * BLOCKS_PER_ROW + ki] = 1'b1;
                    end else begin
                        st = STAT_BAD_INDEX;
                    end
                ACT_COMPUTE:
                    if (ri >= eff_rows() || ci >= eff_cols()) begin
                        st = STAT_BAD_INDEX;
                    end else begin
                        // any infinite or nan scale in use kills the whole element
                        for (b = 0; b < nblk; b++) begin
                            h = scale_mem[ci * BLOCKS_PER_ROW + b];
                            if (h[14:10] == EXP_ALL_ONES) non_finite = 1'b1;
                        end
                        if (non_finite) begin
                            st = STAT_NON_FINITE;
                        end else begin
                            for (b = 0; b < nblk; b++) begin
                                h = scale_mem[ci * BLOCKS_PER_ROW + b];
                                ex = int'(h[14:10]);
                                // zero exponent: subnormal or zero scale adds nothing
                                if (ex != 0) begin
                                    bsum = 0;
                                    hi = ((b + 1) * BLK > len) ? len : (b + 1) * BLK;
                                    for (k = b * BLK; k < hi; k++)
                                        bsum += longint'($signed(a_mem[ri * TILE_D + k])) *
                                                longint'($signed(q_mem[ci * TILE_D + k]));
                                    prod = bsum * longint'(1024 + int'(h[9:0]));
                                    neg = (prod < 0) ^ h[15];
                                    mag = (prod < 0) ? -prod : prod;
                                    // scale into q.8, rounding the magnitude half away
                                    if (ex >= 17)
                                        mag = mag << (ex - 17);
                                    else
                                        mag = (mag + (64'd1 << (16 - ex))) >> (17 - ex);
                                    term = neg ? -longint'(mag) : longint'(mag);
                                    acc += term;
                                    if (acc > longint'(ACC_MAX)) begin
                                        acc = longint'(ACC_MAX);
                                        sat = 1'b1;
                                    end
                                    if (acc < longint'(ACC_MIN)) begin
                                        acc = longint'(ACC_MIN);
                                        sat = 1'b1;
                                    end
                                end
                            end
                            if (sat) st = STAT_SATURATED;
                        end
                    end
            endcase
            if (st == STAT_BAD_INDEX || st == STAT_NON_FINITE) acc = 0;
            r.c = acc[ACC_W-1:0];
            r.status = st;
            pending_c.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endtask

        task check_result(logic [ACC_W-1:0] c, logic [STATUS_W-1:0] status);
            c_result_t e;
            results_seen++;
            if (pending_c.size() == 0) begin
                report($sformatf("result %0d unexpected: c_value %h status %0d",
                                 results_seen, c, status));
                return;
            end
            e = pending_c.pop_front();
            if (c !== e.c)
                report($sformatf("result %0d c_value %h, expected %h", results_seen, c, e.c));
            if (status !== e.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 results_seen, status, e.status));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [ACTION_W-1:0]    s_action;
    logic [ROW_W-1:0]       s_row_index;
    logic [COL_W-1:0]       s_col_index;
    logic [K_W-1:0]         s_k_index;
    logic signed [A_W-1:0]  s_a_value;
    logic signed [Q_W-1:0]  s_b_quant;
    logic [SCALE_W-1:0]     s_b_scale;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [ACC_W-1:0] m_c_value;
    logic [STATUS_W-1:0]    m_status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    c_element_scoreboard sb = new();
    int items_done = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;
    bit s_up = 1'b0;
    bit m_up = 1'b0;

    q8_block_quantized_matmul_tile_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .s_k_index   (s_k_index),
        .s_a_value   (s_a_value),
        .s_b_quant   (s_b_quant),
        .s_b_scale   (s_b_scale),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_c_value   (m_c_value),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // data values with extra weight on the extremes
    function automatic logic signed [A_W-1:0] pick_a();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return A_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [Q_W-1:0] pick_q();
        case ($urandom_range(0, 9))
            0: return 8'sh80;
            1: return 8'sh7F;
            default: return Q_W'($urandom);
        endcase
    endfunction

    // scales: some infinite or nan, some subnormal, many with large exponents
    function automatic logic [SCALE_W-1:0] pick_scale();
        logic [SCALE_W-1:0] h;
        int r;
        h = SCALE_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 6) h[14:10] = EXP_ALL_ONES;
        else if (r < 14) h[14:10] = '0;
        else if (r < 40) h[14:10] = EXP_W'($urandom_range(24, 30));
        else h[14:10] = EXP_W'($urandom_range(1, 23));
        return h;
    endfunction

    function automatic tile_item_t make_item(logic [ACTION_W-1:0] act, int row, int col, int k);
        tile_item_t it;
        it.action = act;
        it.row = ROW_W'(row);
        it.col = COL_W'(col);
        it.k = K_W'(k);
        it.a = pick_a();
        it.q = pick_q();
        it.scale = pick_scale();
        return it;
    endfunction

    function automatic int min_int(int x, int y);
        return (x < y) ? x : y;
    endfunction

    task automatic drop_valid();
        if (s_up) begin
            s_valid <= 1'b0;
            s_up = 1'b0;
        end
    endtask

    // offer one item and hold it until the transaction completes
    task automatic send_item(input tile_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= it.action;
        s_row_index <= it.row;
        s_col_index <= it.col;
        s_k_index <= it.k;
        s_a_value <= it.a;
        s_b_quant <= it.q;
        s_b_scale <= it.scale;
        s_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.predict_item(it);
        items_done++;
    endtask

    task automatic send_fields(logic [ACTION_W-1:0] act, int row, int col, int k,
                               logic [A_W-1:0] a, logic [Q_W-1:0] q, logic [SCALE_W-1:0] h);
        tile_item_t it;
        it = make_item(act, row, col, k);
        it.a = a;
        it.q = q;
        it.scale = h;
        send_item(it);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        drop_valid();
        while (sb.pending_c.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(int len, int rows, int cols, bit poke_unused);
        logic [CFG_DATA_W-1:0] row_data;
        drain();
        row_data = CFG_DATA_W'(rows);
        // upper data bits are beyond the row count register
        if ($urandom_range(0, 3) == 0) row_data[CFG_DATA_W-1:CFG_ROWS_W] = 2'($urandom);
        write_reg(CFG_INNER_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_ROW_COUNT, row_data);
        write_reg(CFG_COL_COUNT, CFG_DATA_W'(cols));
        if (poke_unused) write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // load whatever one c element still needs, then compute it
    task automatic compute_sequence();
        int len;
        int nblk;
        int rows;
        int cols;
        int r;
        int c;
        int k;
        int b;
        tile_item_t it;
        len = sb.eff_len();
        nblk = sb.eff_blocks();
        rows = sb.eff_rows();
        cols = sb.eff_cols();
        if (rows == 0 || cols == 0) begin
            send_item(make_item(ACT_COMPUTE, $urandom, $urandom, $urandom));
            return;
        end
        // mostly a small pool of rows and columns so loads get reused
        r = ($urandom_range(0, 3) != 0) ? $urandom_range(0, min_int(rows, 4) - 1)
                                        : $urandom_range(0, rows - 1);
        c = ($urandom_range(0, 3) != 0) ? $urandom_range(0, min_int(cols, 8) - 1)
                                        : $urandom_range(0, cols - 1);
        for (k = 0; k < len; k++)
            if (!sb.a_set[r * TILE_D + k])
                send_item(make_item(ACT_WRITE_A, r, $urandom, k));
        for (k = 0; k < len; k++)
            if (!sb.q_set[c * TILE_D + k])
                send_item(make_item(ACT_WRITE_QUANT, $urandom, c, k));
        for (b = 0; b < nblk; b++)
            if (!sb.scale_set[c * BLOCKS_PER_ROW + b])
                send_item(make_item(ACT_WRITE_SCALE, $urandom, c, b));
        if (nblk > 0 && $urandom_range(0, 1) == 1)
            send_item(make_item(ACT_WRITE_SCALE, $urandom, c, $urandom_range(0, nblk - 1)));
        // push the first block toward saturation now and then
        if (len > 0 && $urandom_range(0, 19) == 0) begin
            for (k = 0; k < min_int(len, 8); k++) begin
                it = make_item(ACT_WRITE_A, r, $urandom, k);
                it.a = 16'sh8000;
                send_item(it);
                it = make_item(ACT_WRITE_QUANT, $urandom, c, k);
                it.q = $urandom_range(0, 1) ? 8'sh80 : 8'sh7F;
                send_item(it);
            end
            it = make_item(ACT_WRITE_SCALE, $urandom, c, 0);
            it.scale = {1'($urandom), 5'd30, 10'($urandom)};
            send_item(it);
        end
        send_item(make_item(ACT_COMPUTE, r, c, $urandom));
    endtask

    // a single write with its indexes inside the configured ranges, when those are not empty
    task automatic in_range_write();
        int len;
        int nblk;
        int rows;
        int cols;
        tile_item_t it;
        len = sb.eff_len();
        nblk = sb.eff_blocks();
        rows = sb.eff_rows();
        cols = sb.eff_cols();
        it = make_item(WRITE_ACTIONS[$urandom_range(0, 2)], $urandom, $urandom, $urandom);
        case (it.action)
            ACT_WRITE_A:
                if (rows > 0 && len > 0) begin
                    it.row = ROW_W'($urandom_range(0, rows - 1));
                    it.k = K_W'($urandom_range(0, len - 1));
                end
            ACT_WRITE_QUANT:
                if (cols > 0 && len > 0) begin
                    it.col = COL_W'($urandom_range(0, cols - 1));
                    it.k = K_W'($urandom_range(0, len - 1));
                end
            default:
                if (cols > 0 && nblk > 0) begin
                    it.col = COL_W'($urandom_range(0, cols - 1));
                    it.k = K_W'($urandom_range(0, nblk - 1));
                end
        endcase
        send_item(it);
    endtask

    // fully random fields; a compute that would read unloaded entries becomes a write
    task automatic noise_item();
        tile_item_t it;
        it = make_item(ACTION_W'($urandom), $urandom, $urandom, $urandom);
        if (it.action == ACT_COMPUTE && !sb.can_compute(int'(it.row), int'(it.col)))
            it.action = WRITE_ACTIONS[$urandom_range(0, 2)];
        send_item(it);
    endtask

    // short directed pass over the corner cases
    task automatic directed_part();
        // three-element length: one partial block, saturation, nan
        program_regs(3, 16, 64, 1'b0);
        send_fields(ACT_WRITE_A, 0, 5, 0, 16'h8000, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_A, 0, 9, 1, 16'h8000, 8'hFF, 16'hFFFF);
        send_fields(ACT_WRITE_A, 0, 0, 2, 16'h8000, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_QUANT, 7, 0, 0, 16'hFFFF, 8'h80, 16'h0000);
        send_fields(ACT_WRITE_QUANT, 3, 0, 1, 16'h0000, 8'h80, 16'hFFFF);
        send_fields(ACT_WRITE_QUANT, 15, 0, 2, 16'h0000, 8'h80, 16'h0000);
        send_fields(ACT_WRITE_SCALE, 0, 0, 0, 16'h0000, 8'h00, 16'h7BFF);
        send_fields(ACT_COMPUTE, 0, 0, 63, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_fields(ACT_WRITE_SCALE, 0, 0, 0, 16'h0000, 8'h00, 16'h7E00);
        send_fields(ACT_COMPUTE, 0, 0, 0, 16'h0000, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_A, 0, 0, 3, 16'h1234, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_SCALE, 0, 0, 1, 16'h0000, 8'h00, 16'h3C00);
        // one row and one column: bad index wins over a nan scale, then a subnormal scale
        program_regs(3, 1, 1, 1'b1);
        send_fields(ACT_COMPUTE, 1, 0, 0, 16'h0000, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_QUANT, 0, 1, 0, 16'h0000, 8'h7F, 16'h0000);
        send_fields(ACT_WRITE_SCALE, 0, 0, 0, 16'h0000, 8'h00, 16'h8001);
        send_fields(ACT_COMPUTE, 0, 0, 0, 16'h0000, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_SCALE, 0, 0, 0, 16'h0000, 8'h00, 16'hBC00);
        send_fields(ACT_COMPUTE, 0, 0, 0, 16'h0000, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_A, 0, 0, 2, 16'h7FFF, 8'h00, 16'h0000);
        send_fields(ACT_COMPUTE, 0, 0, 0, 16'h0000, 8'h00, 16'h0000);
        // zero length
        program_regs(0, 16, 64, 1'b0);
        send_fields(ACT_COMPUTE, 15, 63, 63, 16'h0000, 8'h00, 16'h0000);
        send_fields(ACT_WRITE_A, 15, 0, 63, 16'h7FFF, 8'h00, 16'h0000);
        // far corners of the stores
        program_regs(64, 16, 64, 1'b0);
        send_fields(ACT_WRITE_A, 15, 63, 63, 16'h7FFF, 8'h7F, 16'hFFFF);
        send_fields(ACT_WRITE_QUANT, 15, 63, 63, 16'hFFFF, 8'h7F, 16'hFFFF);
        send_fields(ACT_WRITE_SCALE, 15, 63, 1, 16'hFFFF, 8'hFF, 16'hFC00);
    endtask

    // main stimulus
    initial begin : stimulus
        int phase;
        int phase_end;
        int r;
        int len;
        int rows;
        int cols;
        s_valid <= 1'b0;
        s_action <= '0;
        s_row_index <= '0;
        s_col_index <= '0;
        s_k_index <= '0;
        s_a_value <= '0;
        s_b_quant <= '0;
        s_b_scale <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_part();
        phase = 0;
        while (items_done < ITEM_GOAL) begin
            // first phases: field maxima, low limits, reset values, all zero
            case (phase)
                0: begin len = 127; rows = 31; cols = 127; end
                1: begin len = 32; rows = 1; cols = 1; end
                2: begin len = 64; rows = 16; cols = 64; end
                3: begin len = 0; rows = 0; cols = 0; end
                default: begin
                    r = $urandom_range(0, 9);
                    len = (r < 4) ? 64 : (r < 6) ? 32 : (r < 8) ? $urandom_range(33, 63) :
                          (r < 9) ? $urandom_range(1, 31) : $urandom_range(0, 127);
                    r = $urandom_range(0, 9);
                    rows = (r < 6) ? $urandom_range(1, 16) : (r < 8) ? 16 :
                           $urandom_range(0, 31);
                    r = $urandom_range(0, 9);
                    cols = (r < 6) ? $urandom_range(1, 64) : (r < 8) ? 64 :
                           $urandom_range(0, 127);
                end
            endcase
            program_regs(len, rows, cols, $urandom_range(0, 7) == 0);
            no_gaps = ($urandom_range(0, 3) == 0);
            // receiver holds off while this phase keeps offering items
            if (phase == 2 || $urandom_range(0, 5) == 0) hold_req = 1'b1;
            phase_end = items_done + ((len == 0 || rows == 0 || cols == 0) ? 20 :
                                      $urandom_range(60, 150));
            while (items_done < phase_end && items_done < ITEM_GOAL) begin
                r = $urandom_range(0, 99);
                if (r < 2) drain();
                else if (r < 40) compute_sequence();
                else if (r < 75) in_range_write();
                else noise_item();
            end
            phase++;
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("q8_block_quantized_matmul_tile_core_tb: PASS");
        end else begin
            $display("q8_block_quantized_matmul_tile_core_tb: FAIL");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            if (hold_req) begin
                if (m_up) m_ready <= 1'b0;
                m_up = 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (gap > 0) begin
                if (m_up) m_ready <= 1'b0;
                m_up = 1'b0;
                repeat (gap) @(posedge aclk);
            end
            if (!m_up) begin
                m_ready <= 1'b1;
                m_up = 1'b1;
            end
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_result(m_c_value, m_status);
        end
    end

    // run limit
    initial begin : watchdog
        #(64'd4_000_000);
        $display("q8_block_quantized_matmul_tile_core_tb: FAIL");
        $finish;
    end

endmodule
